FILE: rtl/core/uartrb_pkg.sv
// Shared types, register map and operation codes of the UART register block.
`timescale 1ns / 1ps

package uartrb_pkg;

   localparam int RX_DEPTH  = 64;
   localparam int RX_IDX_W  = $clog2(RX_DEPTH);
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_RX    = 2'd2;

   localparam logic [11:0] OFF_DATA   = 12'h000;
   localparam logic [11:0] OFF_FLAG   = 12'h018;
   localparam logic [11:0] OFF_IBRD   = 12'h024;
   localparam logic [11:0] OFF_FBRD   = 12'h028;
   localparam logic [11:0] OFF_LCR    = 12'h02c;
   localparam logic [11:0] OFF_CR     = 12'h030;
   localparam logic [11:0] OFF_IFLS   = 12'h034;
   localparam logic [11:0] OFF_IMSC   = 12'h038;
   localparam logic [11:0] OFF_RIS    = 12'h03c;
   localparam logic [11:0] OFF_MIS    = 12'h040;
   localparam logic [11:0] OFF_ICR    = 12'h044;
   localparam logic [11:0] OFF_ID_LO  = 12'hfe0;
   localparam logic [11:0] OFF_ID_HI  = 12'hffc;

   localparam logic [31:0] CR_RESET = 32'h0000_0300;

   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_RD_DATA = 3'd1;
   localparam logic [2:0] OP_RD_REG  = 3'd2;
   localparam logic [2:0] OP_WR_DATA = 3'd3;
   localparam logic [2:0] OP_WR_REG  = 3'd4;
   localparam logic [2:0] OP_WR_MASK = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;
   localparam logic [2:0] OP_RX      = 3'd7;

   localparam logic [3:0] SEL_NONE = 4'd0;
   localparam logic [3:0] SEL_FLAG = 4'd1;
   localparam logic [3:0] SEL_IBRD = 4'd2;
   localparam logic [3:0] SEL_FBRD = 4'd3;
   localparam logic [3:0] SEL_LCR  = 4'd4;
   localparam logic [3:0] SEL_CR   = 4'd5;
   localparam logic [3:0] SEL_IFLS = 4'd6;
   localparam logic [3:0] SEL_IMSC = 4'd7;
   localparam logic [3:0] SEL_RIS  = 4'd8;
   localparam logic [3:0] SEL_MIS  = 4'd9;
   localparam logic [3:0] SEL_ID   = 4'd10;

   typedef struct packed {
      logic [1:0]  mode;
      logic [11:0] offset;
      logic [31:0] write_data;
      logic        rx_present;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_accepted;
      logic        irq_level;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [3:0]  sel;
      logic [31:0] data;
      logic        present;
   } cmd_type;

   function automatic logic [7:0] id_byte(input logic [2:0] idx);
      logic [7:0] val;
      unique case (idx)
         3'd0: val = 8'h11;
         3'd1: val = 8'h10;
         3'd2: val = 8'h14;
         3'd3: val = 8'h00;
         3'd4: val = 8'h0d;
         3'd5: val = 8'hf0;
         3'd6: val = 8'h05;
         3'd7: val = 8'hb1;
         default: val = 8'h00;
      endcase
      return val;
   endfunction

   function automatic logic [RX_IDX_W-1:0] rx_next(input logic [RX_IDX_W-1:0] idx);
      return (idx == RX_IDX_W'(RX_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

endpackage

FILE: rtl/core/uartrb_front.sv
// Front end: decodes each request into an operation and register select.
`timescale 1ns / 1ps

module uartrb_front (
   input  uartrb_pkg::req_type req_data,
   output uartrb_pkg::cmd_type cmd
);

   logic [11:0] off;
   logic        is_id;

   assign off   = req_data.offset;
   assign is_id = (off >= uartrb_pkg::OFF_ID_LO) && (off <= uartrb_pkg::OFF_ID_HI);

   always_comb begin
      cmd         = '0;
      cmd.op      = uartrb_pkg::OP_NOP;
      cmd.sel     = uartrb_pkg::SEL_NONE;
      cmd.present = req_data.rx_present;
      unique case (req_data.mode)
         uartrb_pkg::MODE_READ: begin
            cmd.op = uartrb_pkg::OP_RD_REG;
            if (is_id) begin
               cmd.sel  = uartrb_pkg::SEL_ID;
               cmd.data = {24'd0, uartrb_pkg::id_byte(off[4:2])};
            end else begin
               unique case (off)
                  uartrb_pkg::OFF_DATA: cmd.op  = uartrb_pkg::OP_RD_DATA;
                  uartrb_pkg::OFF_FLAG: cmd.sel = uartrb_pkg::SEL_FLAG;
                  uartrb_pkg::OFF_IBRD: cmd.sel = uartrb_pkg::SEL_IBRD;
                  uartrb_pkg::OFF_FBRD: cmd.sel = uartrb_pkg::SEL_FBRD;
                  uartrb_pkg::OFF_LCR:  cmd.sel = uartrb_pkg::SEL_LCR;
                  uartrb_pkg::OFF_CR:   cmd.sel = uartrb_pkg::SEL_CR;
                  uartrb_pkg::OFF_IFLS: cmd.sel = uartrb_pkg::SEL_IFLS;
                  uartrb_pkg::OFF_IMSC: cmd.sel = uartrb_pkg::SEL_IMSC;
                  uartrb_pkg::OFF_RIS:  cmd.sel = uartrb_pkg::SEL_RIS;
                  uartrb_pkg::OFF_MIS:  cmd.sel = uartrb_pkg::SEL_MIS;
                  default:              cmd.sel = uartrb_pkg::SEL_NONE;
               endcase
            end
         end
         uartrb_pkg::MODE_WRITE: begin
            cmd.data = req_data.write_data;
            unique case (off)
               uartrb_pkg::OFF_DATA: cmd.op = uartrb_pkg::OP_WR_DATA;
               uartrb_pkg::OFF_IBRD: begin
                  cmd.op  = uartrb_pkg::OP_WR_REG;
                  cmd.sel = uartrb_pkg::SEL_IBRD;
               end
               uartrb_pkg::OFF_FBRD: begin
                  cmd.op  = uartrb_pkg::OP_WR_REG;
                  cmd.sel = uartrb_pkg::SEL_FBRD;
               end
               uartrb_pkg::OFF_LCR: begin
                  cmd.op  = uartrb_pkg::OP_WR_REG;
                  cmd.sel = uartrb_pkg::SEL_LCR;
               end
               uartrb_pkg::OFF_CR: begin
                  cmd.op  = uartrb_pkg::OP_WR_REG;
                  cmd.sel = uartrb_pkg::SEL_CR;
               end
               uartrb_pkg::OFF_IFLS: begin
                  cmd.op  = uartrb_pkg::OP_WR_REG;
                  cmd.sel = uartrb_pkg::SEL_IFLS;
               end
               uartrb_pkg::OFF_IMSC: cmd.op = uartrb_pkg::OP_WR_MASK;
               uartrb_pkg::OFF_ICR:  cmd.op = uartrb_pkg::OP_CLEAR;
               default:              cmd.op = uartrb_pkg::OP_NOP;
            endcase
         end
         uartrb_pkg::MODE_RX: begin
            cmd.op   = uartrb_pkg::OP_RX;
            cmd.data = {24'd0, req_data.rx_byte};
         end
         default: cmd.op = uartrb_pkg::OP_NOP;
      endcase
   end

endmodule

FILE: rtl/core/uartrb_cmd_queue.sv
// Short command queue between the decode front end and the execution back end.
`timescale 1ns / 1ps

module uartrb_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uartrb_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                valid,
   output uartrb_pkg::cmd_type head_cmd
);

   uartrb_pkg::cmd_type                   slot_ff [uartrb_pkg::CMD_DEPTH];
   logic [uartrb_pkg::CMD_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [uartrb_pkg::CMD_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [uartrb_pkg::CMD_CNT_W-1:0]      count_ff, count_in;
   logic                                  do_push, do_pop;

   assign full     = (count_ff == uartrb_pkg::CMD_CNT_W'(uartrb_pkg::CMD_DEPTH));
   assign valid    = (count_ff != '0);
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == uartrb_pkg::CMD_PTR_W'(uartrb_pkg::CMD_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == uartrb_pkg::CMD_PTR_W'(uartrb_pkg::CMD_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/core/uartrb_back.sv
// Back end: register file, receive FIFO and interrupt status, two stages deep.
`timescale 1ns / 1ps

module uartrb_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  uartrb_pkg::cmd_type cmd,
   output logic                cmd_pop,
   input  logic                rsp_taken,
   output logic                out_valid,
   output uartrb_pkg::rsp_type out_rsp
);

   logic [7:0]                         rx_mem [uartrb_pkg::RX_DEPTH];
   logic [7:0]                         mem_rd_ff;

   logic [uartrb_pkg::RX_IDX_W-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [uartrb_pkg::RX_IDX_W-1:0]    head_nx, tail_nx;
   logic [31:0]                        ibrd_ff, ibrd_in, fbrd_ff, fbrd_in;
   logic [31:0]                        lcr_ff, lcr_in, cr_ff, cr_in;
   logic [31:0]                        ifls_ff, ifls_in, mask_ff, mask_in;
   logic [1:0]                         raw_ff, raw_in;
   logic [uartrb_pkg::RSP_CNT_W-1:0]   pend_ff, pend_in;

   logic                               b2_valid_ff;
   logic                               b2_pop_ff, b2_pop_in;
   uartrb_pkg::rsp_type                b2_rsp_ff, b2_rsp_in;

   logic                               fire, empty, full;
   logic                               mem_wr, mem_rd;
   logic [31:0]                        status_bits;

   assign empty   = (head_ff == tail_ff);
   assign head_nx = uartrb_pkg::rx_next(head_ff);
   assign tail_nx = uartrb_pkg::rx_next(tail_ff);
   assign full    = (tail_nx == head_ff);
   assign fire    = cmd_valid && (pend_ff < uartrb_pkg::RSP_CNT_W'(uartrb_pkg::RSP_DEPTH));
   assign cmd_pop = fire;

   assign status_bits = {26'd0, raw_ff[1], raw_ff[0], 4'd0};

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      ibrd_in   = ibrd_ff;
      fbrd_in   = fbrd_ff;
      lcr_in    = lcr_ff;
      cr_in     = cr_ff;
      ifls_in   = ifls_ff;
      mask_in   = mask_ff;
      raw_in    = raw_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      b2_pop_in = 1'b0;
      b2_rsp_in = '0;
      if (fire) begin
         unique case (cmd.op)
            uartrb_pkg::OP_RD_DATA: begin
               if (!empty) begin
                  mem_rd    = 1'b1;
                  b2_pop_in = 1'b1;
                  head_in   = head_nx;
                  raw_in    = {1'b1, head_nx != tail_ff};
               end else begin
                  raw_in = 2'b10;
               end
            end
            uartrb_pkg::OP_RD_REG: begin
               unique case (cmd.sel)
                  uartrb_pkg::SEL_FLAG: b2_rsp_in.read_data = {24'd0, 1'b1, 2'b00, empty, 4'd0};
                  uartrb_pkg::SEL_IBRD: b2_rsp_in.read_data = ibrd_ff;
                  uartrb_pkg::SEL_FBRD: b2_rsp_in.read_data = fbrd_ff;
                  uartrb_pkg::SEL_LCR:  b2_rsp_in.read_data = lcr_ff;
                  uartrb_pkg::SEL_CR:   b2_rsp_in.read_data = cr_ff;
                  uartrb_pkg::SEL_IFLS: b2_rsp_in.read_data = ifls_ff;
                  uartrb_pkg::SEL_IMSC: b2_rsp_in.read_data = mask_ff;
                  uartrb_pkg::SEL_RIS:  b2_rsp_in.read_data = status_bits;
                  uartrb_pkg::SEL_MIS:  b2_rsp_in.read_data = status_bits & mask_ff;
                  uartrb_pkg::SEL_ID:   b2_rsp_in.read_data = cmd.data;
                  default:              b2_rsp_in.read_data = '0;
               endcase
            end
            uartrb_pkg::OP_WR_DATA: begin
               b2_rsp_in.tx_valid = 1'b1;
               b2_rsp_in.tx_byte  = cmd.data[7:0];
               raw_in             = {1'b1, !empty};
            end
            uartrb_pkg::OP_WR_REG: begin
               unique case (cmd.sel)
                  uartrb_pkg::SEL_IBRD: ibrd_in = cmd.data;
                  uartrb_pkg::SEL_FBRD: fbrd_in = cmd.data;
                  uartrb_pkg::SEL_LCR:  lcr_in  = cmd.data;
                  uartrb_pkg::SEL_CR:   cr_in   = cmd.data;
                  uartrb_pkg::SEL_IFLS: ifls_in = cmd.data;
                  default:              ;
               endcase
            end
            uartrb_pkg::OP_WR_MASK: begin
               mask_in = cmd.data;
               raw_in  = {1'b1, !empty};
            end
            uartrb_pkg::OP_CLEAR: begin
               raw_in = {1'b1, !empty};
            end
            uartrb_pkg::OP_RX: begin
               if (cmd.present && !full) begin
                  mem_wr                = 1'b1;
                  tail_in               = tail_nx;
                  b2_rsp_in.rx_accepted = 1'b1;
                  raw_in                = 2'b11;
               end else begin
                  raw_in = {1'b1, !empty};
               end
            end
            default: ;
         endcase
      end
      b2_rsp_in.irq_level = (raw_in[0] & mask_in[4]) | (raw_in[1] & mask_in[5]);
   end

   always_comb begin
      unique case ({fire, rsp_taken})
         2'b10:   pend_in = pend_ff + 1'b1;
         2'b01:   pend_in = pend_ff - 1'b1;
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         ibrd_ff     <= '0;
         fbrd_ff     <= '0;
         lcr_ff      <= '0;
         cr_ff       <= uartrb_pkg::CR_RESET;
         ifls_ff     <= '0;
         mask_ff     <= '0;
         raw_ff      <= '0;
         pend_ff     <= '0;
         b2_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         ibrd_ff     <= ibrd_in;
         fbrd_ff     <= fbrd_in;
         lcr_ff      <= lcr_in;
         cr_ff       <= cr_in;
         ifls_ff     <= ifls_in;
         mask_ff     <= mask_in;
         raw_ff      <= raw_in;
         pend_ff     <= pend_in;
         b2_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      b2_pop_ff <= b2_pop_in;
      b2_rsp_ff <= b2_rsp_in;
      if (mem_wr) begin
         rx_mem[tail_ff] <= cmd.data[7:0];
      end
      if (mem_rd) begin
         mem_rd_ff <= rx_mem[head_ff];
      end
   end

   always_comb begin
      out_rsp = b2_rsp_ff;
      if (b2_pop_ff) begin
         out_rsp.read_data = {24'd0, mem_rd_ff};
      end
   end

   assign out_valid = b2_valid_ff;

endmodule

FILE: rtl/core/uartrb_rsp_queue.sv
// Result queue: holds finished responses until the receiver pops them.
`timescale 1ns / 1ps

module uartrb_rsp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uartrb_pkg::rsp_type push_rsp,
   input  logic                pop,
   output logic                empty,
   output uartrb_pkg::rsp_type head_rsp
);

   uartrb_pkg::rsp_type                   slot_ff [uartrb_pkg::RSP_DEPTH];
   logic [uartrb_pkg::RSP_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [uartrb_pkg::RSP_CNT_W-1:0]      count_ff, count_in;
   logic                                  do_pop;

   assign empty    = (count_ff == '0);
   assign head_rsp = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      unique case ({push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_rsp;
      end
   end

endmodule

FILE: rtl/core/uart_register_block_with_rx_fifo_unit.sv
// Top level of the UART register block with receive FIFO.
//
// Usage:
//   Requests (bus read, bus write or host receive event) enter through
//   push/full with the payload on req_data. A request is taken at an edge
//   with push high and full low. Each request gives exactly one response,
//   shown on rsp_data while empty is low and taken at an edge with pop high.
//   Each request passes command queue, execution stages, result queue.
//   Throughput: one request per cycle, sustained while pop keeps up.
//   The decoder writes a two-entry command queue; the execution stage holds
//   the registers and the 64-byte receive memory, whose read data is
//   registered, so a data-register pop takes the second execution stage.
//   Reset clears the FIFO pointers, all registers (control word to 0x300)
//   and both queues; the receive memory itself is not cleared.
//   When the receiver stalls, up to four responses wait in the result queue,
//   then execution holds, the command queue fills and full rises.
`timescale 1ns / 1ps

module uart_register_block_with_rx_fifo_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  uartrb_pkg::req_type req_data,
   output logic                empty,
   input  logic                pop,
   output uartrb_pkg::rsp_type rsp_data
);

   uartrb_pkg::cmd_type dec_cmd, head_cmd;
   uartrb_pkg::rsp_type exe_rsp;
   logic                cmd_valid, cmd_pop, exe_valid, rsp_taken;

   assign rsp_taken = pop && !empty;

   uartrb_front u_front (
      .req_data (req_data),
      .cmd      (dec_cmd)
   );

   uartrb_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (dec_cmd),
      .full     (full),
      .pop      (cmd_pop),
      .valid    (cmd_valid),
      .head_cmd (head_cmd)
   );

   uartrb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (head_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_taken (rsp_taken),
      .out_valid (exe_valid),
      .out_rsp   (exe_rsp)
   );

   uartrb_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (exe_valid),
      .push_rsp (exe_rsp),
      .pop      (pop),
      .empty    (empty),
      .head_rsp (rsp_data)
   );

endmodule

FILE: rtl/core/uartrb_checker.sv
// Port-level checks of the UART register block, bound to the top level.
`timescale 1ns / 1ps

module uartrb_checker (
   input logic                clock,
   input logic                reset,
   input logic                empty,
   input logic                pop,
   input uartrb_pkg::rsp_type rsp_data
);

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result side not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting response changed or vanished");

   a_tx_excl: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.tx_valid) |->
         (rsp_data.read_data == 32'd0 && !rsp_data.rx_accepted))
      else $error("transmit response carries other fields");

   a_tx_byte: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_data.tx_valid) |-> (rsp_data.tx_byte == 8'd0))
      else $error("transmit byte without transmit valid");

endmodule

bind uart_register_block_with_rx_fifo_unit uartrb_checker u_uartrb_checker (
   .clock    (clock),
   .reset    (reset),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

FILE: bench/tb_uart_register_block_with_rx_fifo_unit.sv
// Self-checking bench for the UART register block: own register/FIFO predictor, random traffic.
`timescale 1ns / 1ps

module tb_uart_register_block_with_rx_fifo_unit;

   localparam logic [1:0] MODE_IDLE = 2'd3;
   localparam int CYCLE_LIMIT = 400000;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                push = 1'b0;
   logic                full;
   uartrb_pkg::req_type req_data = '0;
   logic                empty;
   logic                pop = 1'b0;
   uartrb_pkg::rsp_type rsp_data;

   uartrb_pkg::rsp_type pending_replies[$];

   logic [7:0]  ring_mem [64];
   logic [5:0]  ring_head;
   logic [5:0]  ring_tail;
   logic [31:0] baud_int_reg;
   logic [31:0] baud_frac_reg;
   logic [31:0] line_ctrl_reg;
   logic [31:0] ctrl_reg;
   logic [31:0] level_sel_reg;
   logic [31:0] mask_reg;
   logic [1:0]  raw_flags;

   int gap_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int cycle_count = 0;
   int fail_count = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_rx_taken = 0;
   int n_rx_refused = 0;
   int n_tx = 0;
   int n_full_stalls = 0;

   uart_register_block_with_rx_fifo_unit dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic ring_empty();
      return ring_head == ring_tail;
   endfunction

   function automatic logic ring_full();
      return (ring_tail + 6'd1) == ring_head;
   endfunction

   function automatic logic [31:0] status_word();
      return {26'd0, raw_flags[1], raw_flags[0], 4'd0};
   endfunction

   function automatic void latch_raw();
      raw_flags = {1'b1, ~ring_empty()};
   endfunction

   function automatic logic [7:0] id_value(input logic [2:0] idx);
      logic [7:0] v;
      case (idx)
         3'd0: v = 8'h11;
         3'd1: v = 8'h10;
         3'd2: v = 8'h14;
         3'd3: v = 8'h00;
         3'd4: v = 8'h0d;
         3'd5: v = 8'hf0;
         3'd6: v = 8'h05;
         default: v = 8'hb1;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] read_register(input logic [11:0] off);
      logic [31:0] v;
      logic [11:0] rel;
      v = '0;
      if (off >= uartrb_pkg::OFF_ID_LO && off <= uartrb_pkg::OFF_ID_HI) begin
         rel = off - uartrb_pkg::OFF_ID_LO;
         v = {24'd0, id_value(rel[4:2])};
      end else begin
         case (off)
            uartrb_pkg::OFF_DATA: begin
               if (!ring_empty()) begin
                  v = {24'd0, ring_mem[ring_head]};
                  ring_head = ring_head + 6'd1;
               end
               latch_raw();
            end
            uartrb_pkg::OFF_FLAG: v = ring_empty() ? 32'h90 : 32'h80;
            uartrb_pkg::OFF_IBRD: v = baud_int_reg;
            uartrb_pkg::OFF_FBRD: v = baud_frac_reg;
            uartrb_pkg::OFF_LCR:  v = line_ctrl_reg;
            uartrb_pkg::OFF_CR:   v = ctrl_reg;
            uartrb_pkg::OFF_IFLS: v = level_sel_reg;
            uartrb_pkg::OFF_IMSC: v = mask_reg;
            uartrb_pkg::OFF_RIS:  v = status_word();
            uartrb_pkg::OFF_MIS:  v = status_word() & mask_reg;
            default:  v = '0;
         endcase
      end
      return v;
   endfunction

   function automatic uartrb_pkg::rsp_type compute_reply(input uartrb_pkg::req_type r);
      uartrb_pkg::rsp_type o;
      o = '0;
      case (r.mode)
         uartrb_pkg::MODE_READ: o.read_data = read_register(r.offset);
         uartrb_pkg::MODE_WRITE: begin
            case (r.offset)
               uartrb_pkg::OFF_DATA: begin
                  o.tx_valid = 1'b1;
                  o.tx_byte = r.write_data[7:0];
                  latch_raw();
               end
               uartrb_pkg::OFF_IBRD: baud_int_reg = r.write_data;
               uartrb_pkg::OFF_FBRD: baud_frac_reg = r.write_data;
               uartrb_pkg::OFF_LCR:  line_ctrl_reg = r.write_data;
               uartrb_pkg::OFF_CR:   ctrl_reg = r.write_data;
               uartrb_pkg::OFF_IFLS: level_sel_reg = r.write_data;
               uartrb_pkg::OFF_IMSC: begin
                  mask_reg = r.write_data;
                  latch_raw();
               end
               uartrb_pkg::OFF_ICR:  latch_raw();
               default: ;
            endcase
         end
         uartrb_pkg::MODE_RX: begin
            if (r.rx_present && !ring_full()) begin
               ring_mem[ring_tail] = r.rx_byte;
               ring_tail = ring_tail + 6'd1;
               o.rx_accepted = 1'b1;
            end
            latch_raw();
         end
         default: ;
      endcase
      o.irq_level = |(status_word() & mask_reg);
      return o;
   endfunction

   function automatic uartrb_pkg::req_type make_req(input logic [1:0] mode,
                                                    input logic [11:0] off,
                                                    input logic [31:0] wdata,
                                                    input logic present,
                                                    input logic [7:0] rx_byte);
      uartrb_pkg::req_type r;
      r.mode = mode;
      r.offset = off;
      r.write_data = wdata;
      r.rx_present = present;
      r.rx_byte = rx_byte;
      return r;
   endfunction

   task automatic compare_field(input string name, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s expected %h got %h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_cycles > 0) begin
         pop <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         pop <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      uartrb_pkg::rsp_type want;
      if (!reset && pop && !empty) begin
         if (pending_replies.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_replies.pop_front();
            compare_field("read_data", want.read_data, rsp_data.read_data);
            compare_field("tx_valid", 32'(want.tx_valid), 32'(rsp_data.tx_valid));
            compare_field("tx_byte", 32'(want.tx_byte), 32'(rsp_data.tx_byte));
            compare_field("rx_accepted", 32'(want.rx_accepted), 32'(rsp_data.rx_accepted));
            compare_field("irq_level", 32'(want.irq_level), 32'(rsp_data.irq_level));
            n_checked++;
         end
      end
   end

   task automatic issue_request(input uartrb_pkg::req_type r);
      uartrb_pkg::rsp_type o;
      push <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (full) begin
         n_full_stalls++;
         @(posedge clock);
      end
      o = compute_reply(r);
      pending_replies.push_back(o);
      n_requests++;
      if (o.tx_valid) n_tx++;
      if (r.mode == uartrb_pkg::MODE_RX && r.rx_present) begin
         if (o.rx_accepted) n_rx_taken++;
         else n_rx_refused++;
      end
      if ($urandom_range(99) < gap_pct) begin
         push <= 1'b0;
         req_data <= make_req(2'($urandom), 12'($urandom), $urandom, 1'($urandom),
                              8'($urandom));
         @(posedge clock);
         while ($urandom_range(99) < gap_pct) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_reset_state();
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_FLAG, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_CR, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_RIS, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_MIS, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_ID_LO, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_ID_HI, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, 12'hfe5, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, 12'hfff, 32'h0, 1'b0, 8'h00));
      wait_drained();
   endtask

   task automatic test_register_access();
      issue_request(make_req(uartrb_pkg::MODE_WRITE, uartrb_pkg::OFF_IBRD, 32'hffff_ffff,
                             1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_IBRD, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_WRITE, uartrb_pkg::OFF_CR, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_CR, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_WRITE, uartrb_pkg::OFF_IMSC, 32'hffff_ffff,
                             1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_WRITE, uartrb_pkg::OFF_RIS, 32'hffff_ffff,
                             1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_RIS, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_WRITE, uartrb_pkg::OFF_DATA, 32'hffff_ffa5,
                             1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_WRITE, uartrb_pkg::OFF_ICR, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_WRITE, 12'h3fc, 32'hffff_ffff, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, 12'h3fc, 32'h0, 1'b0, 8'h00));
      wait_drained();
   endtask

   task automatic test_receive_path();
      issue_request(make_req(uartrb_pkg::MODE_RX, uartrb_pkg::OFF_DATA, 32'h0, 1'b0, 8'h5a));
      issue_request(make_req(uartrb_pkg::MODE_RX, uartrb_pkg::OFF_DATA, 32'h0, 1'b1, 8'hff));
      issue_request(make_req(uartrb_pkg::MODE_RX, uartrb_pkg::OFF_DATA, 32'h0, 1'b1, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_FLAG, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, 32'h0, 1'b0, 8'h00));
      issue_request(make_req(MODE_IDLE, uartrb_pkg::OFF_DATA, 32'hffff_ffff, 1'b1, 8'hff));
      wait_drained();
   endtask

   task automatic test_fifo_overflow();
      int extra;
      extra = 0;
      while (extra < 3) begin
         if (ring_full()) extra++;
         issue_request(make_req(uartrb_pkg::MODE_RX, 12'($urandom), $urandom, 1'b1,
                                8'($urandom)));
      end
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_FLAG, $urandom, 1'b0,
                             8'($urandom)));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_MIS, $urandom, 1'b0,
                             8'($urandom)));
      while (!ring_empty())
         issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, $urandom,
                                1'($urandom), 8'($urandom)));
      issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, $urandom,
                             1'($urandom), 8'($urandom)));
      wait_drained();
   endtask

   task automatic test_backpressure();
      gap_pct = 0;
      hold_cycles = 80;
      repeat (24) begin
         if ($urandom_range(1)) issue_request(make_req(uartrb_pkg::MODE_RX, 12'($urandom),
                                                       $urandom, 1'b1, 8'($urandom)));
         else issue_request(make_req(uartrb_pkg::MODE_READ, uartrb_pkg::OFF_DATA, $urandom,
                                     1'($urandom), 8'($urandom)));
      end
      wait_drained();
   endtask

   function automatic logic [11:0] pick_offset();
      logic [11:0] off;
      int s;
      s = $urandom_range(9);
      if (s == 7) begin
         off = uartrb_pkg::OFF_ID_LO + 12'($urandom_range(31));
      end else if (s > 7) begin
         off = 12'($urandom);
      end else begin
         case ($urandom_range(11))
            0: off = uartrb_pkg::OFF_DATA;
            1: off = uartrb_pkg::OFF_FLAG;
            2: off = uartrb_pkg::OFF_IBRD;
            3: off = uartrb_pkg::OFF_FBRD;
            4: off = uartrb_pkg::OFF_LCR;
            5: off = uartrb_pkg::OFF_CR;
            6: off = uartrb_pkg::OFF_IFLS;
            7: off = uartrb_pkg::OFF_IMSC;
            8: off = uartrb_pkg::OFF_RIS;
            9: off = uartrb_pkg::OFF_MIS;
            10: off = uartrb_pkg::OFF_ICR;
            default: off = uartrb_pkg::OFF_DATA;
         endcase
      end
      return off;
   endfunction

   function automatic uartrb_pkg::req_type random_mixed();
      uartrb_pkg::req_type r;
      int m;
      int w;
      m = $urandom_range(99);
      w = $urandom_range(9);
      r = make_req(uartrb_pkg::MODE_READ, pick_offset(), $urandom, $urandom_range(9) != 0,
                   8'($urandom));
      if (m >= 95) r.mode = MODE_IDLE;
      else if (m >= 60) r.mode = uartrb_pkg::MODE_RX;
      else if (m >= 35) r.mode = uartrb_pkg::MODE_WRITE;
      if (w == 0) r.write_data = '0;
      else if (w == 1) r.write_data = '1;
      return r;
   endfunction

   task automatic test_random_traffic(input int per_phase);
      int phase;
      int count;
      int len;
      int kind;
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 51; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 51; end
            default: begin gap_pct = 29; stall_pct = 29; end
         endcase
         count = 0;
         while (count < per_phase) begin
            kind = $urandom_range(9);
            len = $urandom_range(4, 16);
            repeat (len) begin
               if (kind < 3)
                  issue_request(make_req(uartrb_pkg::MODE_RX, 12'($urandom), $urandom,
                                         $urandom_range(9) != 0, 8'($urandom)));
               else if (kind < 5)
                  issue_request(make_req(uartrb_pkg::MODE_READ,
                                         ($urandom_range(4) != 0) ?
                                         uartrb_pkg::OFF_DATA : pick_offset(),
                                         $urandom, 1'($urandom), 8'($urandom)));
               else
                  issue_request(random_mixed());
            end
            count += len;
         end
         wait_drained();
      end
   endtask

   initial begin
      ring_head = '0;
      ring_tail = '0;
      baud_int_reg = '0;
      baud_frac_reg = '0;
      line_ctrl_reg = '0;
      ctrl_reg = uartrb_pkg::CR_RESET;
      level_sel_reg = '0;
      mask_reg = '0;
      raw_flags = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_register_access();
      test_receive_path();
      test_fifo_overflow();
      test_backpressure();
      test_random_traffic(300);

      push <= 1'b0;
      stall_pct = 0;
      wait_drained();
      $display("covered %0d requests, %0d responses checked, %0d tx chars",
               n_requests, n_checked, n_tx);
      $display("rx bytes taken %0d, refused when full %0d, input stalls %0d",
               n_rx_taken, n_rx_refused, n_full_stalls);
      if (fail_count == 0 && pending_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
